FILE: rtl/core/csvadc_pkg.sv
// ----------------------------------------------------------------------------
// csvadc_pkg
// Shared types and constants for the CSV line parser and ADC calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package csvadc_pkg;

	localparam int MAX_CH       = 4;
	localparam int CHANNELS_DEF = 4;
	localparam int IDX_W        = $clog2(MAX_CH);
	localparam int COUNT_W      = 3;
	localparam int BYTE_W       = 8;
	localparam int VALUE_W      = 16;
	localparam int CAL_W        = 24;
	localparam int CUR_W        = 32;
	localparam int MAG_W        = 32;
	localparam int CFG_IDX_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_BASE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BASE = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END         = 4'd8;

	localparam logic signed [CAL_W-1:0] GAIN_RESET   = 24'sd26508;
	localparam logic signed [CAL_W-1:0] OFFSET_RESET = 24'sd16304;

	localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHR_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CHR_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CHR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHR_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CHR_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CHR_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CHR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHR_NINE  = 8'h39;

	localparam logic [MAG_W:0] MAG_LIMIT = 33'h0_8000_0000;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_NUM,
		PH_JUNK
	} phase_t;

	typedef struct packed {
		logic                            emit;
		logic [MAX_CH-1:0][VALUE_W-1:0] values;
	} line_t;

endpackage

`default_nettype wire

FILE: rtl/core/csvadc_parser.sv
// ----------------------------------------------------------------------------
// csvadc_parser
// Byte-wise CSV field parser; flags a complete line of channel values.
// ----------------------------------------------------------------------------
`default_nettype none

module csvadc_parser
	import csvadc_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output line_t                  line
);

	localparam logic [COUNT_W-1:0] CH_CNT  = COUNT_W'(CHANNELS);
	localparam logic [COUNT_W-1:0] CH_OVER = COUNT_W'(CHANNELS + 1);

	phase_t                         phase_q, phase_n;
	logic [MAG_W-1:0]               mag_q, mag_n;
	logic                           neg_q, neg_n;
	logic                           seen_q, seen_n;
	logic                           ovf_q, ovf_n;
	logic [COUNT_W-1:0]             count_q, count_n;
	logic [MAX_CH-1:0][VALUE_W-1:0] store_q, store_closed;

	logic                           is_digit;
	logic                           field_ok;
	logic                           do_store;
	logic [VALUE_W-1:0]             field_val;
	logic [COUNT_W-1:0]             count_closed;
	logic [MAG_W+2:0]               mag_next;
	logic                           store_we;

	always_comb begin
		is_digit  = (rx_byte >= CHR_ZERO) && (rx_byte <= CHR_NINE);
		field_ok  = seen_q && !ovf_q && (neg_q || !mag_q[MAG_W-1]);
		field_val = neg_q ? (VALUE_W'(0) - mag_q[VALUE_W-1:0]) : mag_q[VALUE_W-1:0];
		do_store  = field_ok && (count_q < CH_CNT);
		mag_next  = ({3'b000, mag_q} * 35'd10) + {31'd0, rx_byte[3:0]};

		if (!field_ok)
			count_closed = count_q;
		else if (count_q < CH_CNT)
			count_closed = count_q + COUNT_W'(1);
		else
			count_closed = CH_OVER;

		store_closed = store_q;
		if (do_store)
			store_closed[count_q[IDX_W-1:0]] = field_val;

		phase_n     = phase_q;
		mag_n       = mag_q;
		neg_n       = neg_q;
		seen_n      = seen_q;
		ovf_n       = ovf_q;
		count_n     = count_q;
		store_we    = 1'b0;
		line.emit   = 1'b0;
		line.values = store_closed;

		case (rx_byte)
			CHR_CR: begin
			end
			CHR_LF, CHR_COMMA: begin
				store_we = do_store;
				phase_n  = PH_LEAD;
				mag_n    = '0;
				neg_n    = 1'b0;
				seen_n   = 1'b0;
				ovf_n    = 1'b0;
				if (rx_byte == CHR_LF) begin
					line.emit = (count_closed == CH_CNT);
					count_n   = '0;
				end else begin
					count_n = count_closed;
				end
			end
			default: begin
				case (phase_q)
					PH_LEAD: begin
						if (rx_byte inside {CHR_SP, CHR_TAB, CHR_VT, CHR_FF}) begin
							phase_n = PH_LEAD;
						end else if (rx_byte inside {CHR_PLUS, CHR_MINUS}) begin
							neg_n   = (rx_byte == CHR_MINUS);
							phase_n = PH_NUM;
						end else if (is_digit) begin
							phase_n = PH_NUM;
							seen_n  = 1'b1;
							if (mag_next > {2'b00, MAG_LIMIT})
								ovf_n = 1'b1;
							else
								mag_n = mag_next[MAG_W-1:0];
						end else begin
							phase_n = PH_JUNK;
						end
					end
					PH_NUM: begin
						if (is_digit) begin
							seen_n = 1'b1;
							if (!ovf_q) begin
								if (mag_next > {2'b00, MAG_LIMIT})
									ovf_n = 1'b1;
								else
									mag_n = mag_next[MAG_W-1:0];
							end
						end else begin
							phase_n = PH_JUNK;
						end
					end
					default: begin
						phase_n = PH_JUNK;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			mag_q   <= mag_n;
			neg_q   <= neg_n;
			seen_q  <= seen_n;
			ovf_q   <= ovf_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store_we)
			store_q <= store_closed;
	end

endmodule

`default_nettype wire

FILE: rtl/core/csvadc_cal_lane.sv
// ----------------------------------------------------------------------------
// csvadc_cal_lane
// One calibration lane: gain multiply, then offset, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module csvadc_cal_lane
	import csvadc_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      load_s2,
	input  wire logic                      load_out,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire logic signed [CAL_W-1:0]   gain,
	input  wire logic signed [CAL_W-1:0]   offset,
	output logic signed [CUR_W-1:0]        current
);

	localparam int PROD_W = VALUE_W + CAL_W;
	localparam int SUM_W  = PROD_W + 1;

	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-9:0]  quo;
	logic signed [CUR_W-1:0]  sat;
	logic signed [CUR_W-1:0]  cur_q;

	always_comb begin
		sum = SUM_W'(prod_s2) + SUM_W'($signed({offset, 8'h00})) + SUM_W'(128);
		quo = sum[SUM_W-1:8];
		if (quo[CUR_W] != quo[CUR_W-1])
			sat = quo[CUR_W] ? {1'b1, {(CUR_W-1){1'b0}}} : {1'b0, {(CUR_W-1){1'b1}}};
		else
			sat = quo[CUR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (load_s2)
			prod_s2 <= value * gain;
		if (load_out)
			cur_q <= sat;
	end

	assign current = cur_q;

endmodule

`default_nettype wire

FILE: rtl/core/csv_adc_line_parser_calibrator.sv
// ----------------------------------------------------------------------------
// csv_adc_line_parser_calibrator
// Parses comma-separated ADC counts from a byte stream and emits calibrated
// channel currents for every line that holds a full set of values.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while in_ready is high. A newline closing
// a line with exactly CHANNELS valid values starts a result through three
// register stages (line values, gain products, rounded and saturated
// currents). Each stage holds only while the next is full and stalled, so
// bytes can keep flowing while a result waits at the output. The user must
// write gain and offset registers via the cfg port (indices 0..3 gain, 4..7
// offset, others ignored) only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_adc_line_parser_calibrator
	import csvadc_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [CUR_W-1:0]   current_0,
	output logic signed [CUR_W-1:0]   current_1,
	output logic signed [CUR_W-1:0]   current_2,
	output logic signed [CUR_W-1:0]   current_3,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CAL_W-1:0]     cfg_data
);

	logic signed [CAL_W-1:0]        gain_q   [MAX_CH];
	logic signed [CAL_W-1:0]        offset_q [MAX_CH];
	logic [MAX_CH-1:0][VALUE_W-1:0] values_s1;
	logic signed [CUR_W-1:0]        cur      [MAX_CH];

	line_t line;
	logic  valid_s1, valid_s2, valid_q;
	logic  rdy1, rdy2, rdy3;
	logic  accept;
	logic  cfg_we;

	assign rdy3      = !valid_q || out_ready;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign in_ready  = rdy1;
	assign accept    = in_valid && rdy1;
	assign out_valid = valid_q;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	csvadc_parser #(
		.CHANNELS(CHANNELS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.rx_byte(rx_byte),
		.line   (line)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (rdy1)
				valid_s1 <= accept && line.emit;
			if (rdy2)
				valid_s2 <= valid_s1;
			if (rdy3)
				valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && line.emit)
			values_s1 <= line.values;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CH; i++) begin
				gain_q[i]   <= GAIN_RESET;
				offset_q[i] <= OFFSET_RESET;
			end
		end else if (cfg_we) begin
			if (cfg_index < REG_OFFSET_BASE)
				gain_q[cfg_index[IDX_W-1:0]] <= cfg_data;
			else if (cfg_index < REG_END)
				offset_q[cfg_index[IDX_W-1:0]] <= cfg_data;
		end
	end

	for (genvar j = 0; j < MAX_CH; j++) begin : g_lane
		if (j < CHANNELS) begin : g_on
			csvadc_cal_lane u_lane (
				.clk     (clk),
				.load_s2 (rdy2 && valid_s1),
				.load_out(rdy3 && valid_s2),
				.value   (values_s1[j]),
				.gain    (gain_q[j]),
				.offset  (offset_q[j]),
				.current (cur[j])
			);
		end else begin : g_off
			assign cur[j] = '0;
		end
	end

	assign current_0 = cur[0];
	assign current_1 = cur[1];
	assign current_2 = cur[2];
	assign current_3 = cur[3];

endmodule

`default_nettype wire
